### sv/flfr_pkg.sv
// ----------------------------------------------------------------------------
// flfr_pkg
// Shared types and constants of the fire loop frame responder.
// ----------------------------------------------------------------------------
package flfr_pkg;

   localparam logic [2:0] KIND_EDGE    = 3'd0;
   localparam logic [2:0] KIND_TIMEOUT = 3'd1;
   localparam logic [2:0] KIND_HALFSEC = 3'd2;
   localparam logic [2:0] KIND_KEY     = 3'd3;
   localparam logic [2:0] KIND_PWM     = 3'd4;

   localparam logic [5:0] IDLE_STEP = 6'd63;
   localparam logic [7:0] DEV_TYPE  = 8'd1;

   localparam logic [6:0] SEQ_ADDR0 = 7'h7f;
   localparam logic [6:0] SEQ_ADDR1 = 7'h55;
   localparam logic [6:0] SEQ_ADDR2 = 7'h25;
   localparam logic [6:0] SEQ_ADDR3 = 7'h65;
   localparam logic [6:0] SEQ_WRITE = 7'h3c;
   localparam logic [6:0] SEQ_READ  = 7'h3b;

   localparam logic [7:0] START_MIN   = 8'd35;
   localparam logic [7:0] RESTART_MIN = 8'd145;
   localparam logic [7:0] GAP_MAX     = 8'd80;
   localparam logic [7:0] ONE_MIN     = 8'd17;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;

   typedef struct packed {
      logic [2:0] kind;
      logic       line_high;
      logic [7:0] interval;
      logic       key_pressed;
   } item_type;

   typedef struct packed {
      logic       reply_pulse;
      logic       led_on;
      logic       store_address;
      logic [6:0] new_address;
      logic       watchdog_kick;
   } result_type;

endpackage

### sv/fire_loop_frame_responder_core.sv
// ----------------------------------------------------------------------------
// fire_loop_frame_responder_core
// Slave responder of a two-wire alarm loop: frame decode, replies and LED.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ carries one event transaction (edge, timeout, tick, key, PWM tick).
//  - rsp_ returns exactly one result transaction per event, in order.
//  - csr_we/csr_wdata load the boot address; also reloads the device address.
//    Write only while idle.
// Structure: a two-entry queue front end decouples req_ from the engine; the
//  engine evaluates one event per cycle, unless rsp_tready stalls it, into an output register.
// Path: an event goes through the queue entry, then the result register;
//  rsp_tvalid rises once its result is in the result register.
// Throughput: one transaction per cycle while rsp_tready is high, set by the engine step.
// Reset (synchronous): frame idle, LED off, flash allowed, address 0, queue empty.
// Stall: when rsp_tready is low the result holds, the engine stops and the
//  queue absorbs up to two more events before req_tready drops.
// ----------------------------------------------------------------------------
module fire_loop_frame_responder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [6:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // kind[2:0], line_high[3], interval[11:4], key_pressed[12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // reply_pulse[0], led_on[1], store_address[2],
                                    // new_address[9:3], watchdog_kick[10]
);

   flfr_pkg::item_type   in_item, q_item;
   flfr_pkg::result_type res;
   logic q_valid, q_ready;

   assign in_item.kind        = req_tdata[2:0];
   assign in_item.line_high   = req_tdata[3];
   assign in_item.interval    = req_tdata[11:4];
   assign in_item.key_pressed = req_tdata[12];

   flfr_queue u_queue (
      .clock, .reset,
      .in_valid(req_tvalid), .in_ready(req_tready), .in_item(in_item),
      .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
   );

   flfr_engine u_engine (
      .clock, .reset, .csr_we, .csr_wdata,
      .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_result(res)
   );

   assign rsp_tdata = {5'b0, res.watchdog_kick, res.new_address, res.store_address,
                       res.led_on, res.reply_pulse};

endmodule

### sv/flfr_queue.sv
// ----------------------------------------------------------------------------
// flfr_queue
// Two-entry FIFO between the front end and the protocol engine.
// ----------------------------------------------------------------------------
module flfr_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  flfr_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output flfr_pkg::item_type out_item
);

   flfr_pkg::item_type           mem_ff [flfr_pkg::QUEUE_DEPTH];
   logic [flfr_pkg::QUEUE_AW-1:0] wr_ff, rd_ff;
   logic [flfr_pkg::QUEUE_AW:0]   cnt_ff;
   logic push, pop;

   assign in_ready  = (cnt_ff != flfr_pkg::QUEUE_AW'(0) + (flfr_pkg::QUEUE_AW+1)'(flfr_pkg::QUEUE_DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign out_item  = mem_ff[rd_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= in_item;
      if (reset) begin
         wr_ff <= '0; rd_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop) rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (flfr_pkg::QUEUE_AW+1)'(push) - (flfr_pkg::QUEUE_AW+1)'(pop);
      end
   end

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (flfr_pkg::QUEUE_AW+1)'(flfr_pkg::QUEUE_DEPTH)) else $error("queue overflow");
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> cnt_ff == $past(cnt_ff) + 1'b1) else $error("count slip");
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> cnt_ff == $past(cnt_ff) - 1'b1) else $error("count slip");
`endif

endmodule

### sv/flfr_engine.sv
// ----------------------------------------------------------------------------
// flfr_engine
// Frame decode, reply and LED engine; one item per cycle, unless out_ready holds the result, into an output register.
// ----------------------------------------------------------------------------
module flfr_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [6:0]           csr_wdata,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  flfr_pkg::item_type   in_item,
   output logic                 out_valid,
   input  logic                 out_ready,
   output flfr_pkg::result_type out_result
);

   logic [5:0] step_ff, step_in;
   logic [2:0] cmd_ff, cmd_in;
   logic [6:0] addr_ff, addr_in;
   logic [2:0] wseq_ff, wseq_in;
   logic [7:0] rsh_ff, rsh_in;
   logic par_ff, par_in;
   logic [3:0] slots_ff, slots_in;
   logic act_ff, act_in, pend_ff, pend_in;
   logic lcmd_ff, lcmd_in, lph_ff, lph_in, llev_ff, llev_in, flash_ff, flash_in;
   logic [6:0] dev_ff, dev_in;
   logic valid_ff;
   flfr_pkg::result_type res_ff, res_in;
   logic take;

   assign in_ready   = !valid_ff || out_ready;
   assign take       = in_valid && in_ready;
   assign out_valid  = valid_ff;
   assign out_result = res_ff;

   always_comb begin
      logic pulse, store, kick, addrd, bitv;
      logic [6:0] naddr;
      logic [7:0] mask;
      logic usep, snd;
      step_in = step_ff; cmd_in = cmd_ff; addr_in = addr_ff; wseq_in = wseq_ff;
      rsh_in = rsh_ff; par_in = par_ff; slots_in = slots_ff; act_in = act_ff;
      pend_in = pend_ff; lcmd_in = lcmd_ff; lph_in = lph_ff; llev_in = llev_ff;
      flash_in = flash_ff; dev_in = dev_ff;
      pulse = 1'b0; store = 1'b0; kick = 1'b0; naddr = '0; bitv = 1'b0;
      mask = '0; usep = 1'b0; snd = 1'b0;
      addrd = (addr_ff == dev_ff) && (dev_ff != '0);
      case (in_item.kind)
         flfr_pkg::KIND_EDGE: begin
            if (step_ff == flfr_pkg::IDLE_STEP) begin
               if (!in_item.line_high) begin
                  step_in = '0;
                  if (!lcmd_ff) llev_in = 1'b0;
               end
            end else if (in_item.line_high) begin
               if (in_item.interval > flfr_pkg::START_MIN) begin
                  if (in_item.interval < flfr_pkg::RESTART_MIN) begin
                     addr_in = '0; cmd_in = '0; step_in = 6'd1;
                     if (!lcmd_ff) llev_in = 1'b0;
                  end else step_in = '0;
               end else if (step_ff > 6'd10) begin
                  // reply slot on falling loop voltage
                  if (step_ff == 6'd11) begin
                     par_in = 1'b0;
                     if (slots_ff != '0) begin
                        pulse = 1'b1;
                        if (addrd) rsh_in = act_ff ? 8'd64 : 8'd16;
                     end else rsh_in = act_ff ? 8'd64 : 8'd16;
                  end else begin
                     if (addrd) begin
                        if (step_ff < 6'd19) begin
                           mask = 8'd64; usep = 1'b1; snd = 1'b1;
                        end else if (step_ff < 6'd32) begin
                           mask = (step_ff < 6'd25) ? 8'd4 : 8'd64;
                           usep = 1'b1; snd = 1'b1;
                        end else if (step_ff == 6'd32) begin
                           par_in = !par_ff; pulse = 1'b1;
                        end else if (step_ff == 6'd41) begin
                           pulse = par_ff;
                        end
                        if (snd) begin
                           pulse = |(rsh_ff & mask);
                           if (pulse) par_in = !par_ff;
                           rsh_in = {rsh_ff[6:0], 1'b0};
                           if (step_ff == 6'd18) rsh_in = act_ff ? 8'd5 : 8'd2;
                           if (step_ff == 6'd21) rsh_in = flfr_pkg::DEV_TYPE;
                           if (step_ff == 6'd24) rsh_in = {1'b0, dev_ff};
                        end
                     end
                     if (slots_ff != '0) begin
                        if (step_ff == 6'd41) rsh_in = {1'b0, dev_ff};
                        if (step_ff > 6'd41 && step_ff < 6'd49) begin
                           if (rsh_ff[6]) pulse = 1'b1;
                           rsh_in = {rsh_ff[6:0], 1'b0};
                           if (step_ff == 6'd48) slots_in = slots_ff - 4'd1;
                        end
                     end
                  end
               end
            end else if (step_ff != '0) begin
               if (in_item.interval > flfr_pkg::GAP_MAX) step_in = '0;
               else if (step_ff < 6'd11) begin
                  bitv = !(in_item.interval < flfr_pkg::ONE_MIN);
                  if (step_ff < 6'd4) cmd_in = {cmd_ff[1:0], bitv};
                  else addr_in = {addr_ff[5:0], bitv};
                  step_in = step_ff + 6'd1;
                  if (step_ff == 6'd10) begin
                     kick = 1'b1;
                     // header complete
                     if (addr_in == flfr_pkg::SEQ_ADDR0) begin
                        wseq_in = 3'd1; step_in = '0;
                     end else begin
                        case (wseq_ff)
                           3'd1: wseq_in = (addr_in == flfr_pkg::SEQ_ADDR1) ? 3'd2 : 3'd0;
                           3'd2: wseq_in = (addr_in == flfr_pkg::SEQ_ADDR2) ? 3'd3 : 3'd0;
                           3'd3: wseq_in = (addr_in == flfr_pkg::SEQ_ADDR3) ? 3'd4 : 3'd0;
                           3'd4: wseq_in = (addr_in == flfr_pkg::SEQ_WRITE) ? 3'd5 :
                                           (addr_in == flfr_pkg::SEQ_READ) ? 3'd6 : 3'd0;
                           3'd5: begin
                              if (addr_in != '0 && addr_in != 7'd127 && addr_in != dev_ff) begin
                                 store = 1'b1; naddr = addr_in; dev_in = addr_in;
                              end
                              wseq_in = '0; step_in = '0;
                           end
                           default: ;
                        endcase
                     end
                     if (step_in != '0) begin
                        if (wseq_in == 3'd6) begin
                           if (dev_in != '0) begin
                              addr_in = dev_in;
                              if (flash_ff) begin llev_in = 1'b1; flash_in = 1'b0; end
                           end else step_in = '0;
                           wseq_in = '0;
                        end else begin
                           if (pend_ff) begin
                              pend_in = 1'b0;
                              if (act_ff) slots_in = 4'd8;
                           end
                           if (addr_in == dev_in && dev_in != '0) begin
                              if (cmd_in[2]) begin
                                 if (!lcmd_ff) begin
                                    lcmd_in = 1'b1; llev_in = 1'b1; lph_in = 1'b1;
                                 end
                              end else if (lcmd_ff) begin
                                 lcmd_in = 1'b0; llev_in = 1'b0; lph_in = 1'b0;
                              end else if (flash_ff) begin
                                 llev_in = 1'b1; flash_in = 1'b0;
                              end
                           end else if (slots_in == '0) step_in = '0;
                        end
                     end
                  end
               end else step_in = (step_ff < 6'd48) ? step_ff + 6'd1 : 6'd0;
            end
         end
         flfr_pkg::KIND_TIMEOUT: begin
            step_in = flfr_pkg::IDLE_STEP; addr_in = '0; cmd_in = '0;
            if (!lcmd_ff) llev_in = 1'b0;
         end
         flfr_pkg::KIND_HALFSEC: flash_in = 1'b1;
         flfr_pkg::KIND_KEY: begin
            if (in_item.key_pressed) begin
               if (!act_ff && !lcmd_ff && slots_ff == '0) pend_in = 1'b1;
               act_in = 1'b1;
            end else act_in = 1'b0;
         end
         flfr_pkg::KIND_PWM: begin
            if (lcmd_ff) begin lph_in = !lph_ff; llev_in = !lph_ff; end
         end
         default: ;
      endcase
      res_in.reply_pulse   = pulse;
      res_in.led_on        = llev_in;
      res_in.store_address = store;
      res_in.new_address   = naddr;
      res_in.watchdog_kick = kick;
   end

   always_ff @(posedge clock) begin
      if (take) res_ff <= res_in;
      if (reset) begin
         step_ff <= flfr_pkg::IDLE_STEP; cmd_ff <= '0; addr_ff <= '0; wseq_ff <= '0;
         rsh_ff <= '0; par_ff <= 1'b0; slots_ff <= '0; act_ff <= 1'b0; pend_ff <= 1'b0;
         lcmd_ff <= 1'b0; lph_ff <= 1'b0; llev_ff <= 1'b0; flash_ff <= 1'b1;
         dev_ff <= '0; valid_ff <= 1'b0;
      end else begin
         if (take) begin
            step_ff <= step_in; cmd_ff <= cmd_in; addr_ff <= addr_in; wseq_ff <= wseq_in;
            rsh_ff <= rsh_in; par_ff <= par_in; slots_ff <= slots_in; act_ff <= act_in;
            pend_ff <= pend_in; lcmd_ff <= lcmd_in; lph_ff <= lph_in; llev_ff <= llev_in;
            flash_ff <= flash_in;
         end
         // boot address write reloads the device address
         if (csr_we) dev_ff <= csr_wdata;
         else if (take) dev_ff <= dev_in;
         if (take) valid_ff <= 1'b1;
         else if (out_ready) valid_ff <= 1'b0;
      end
   end

`ifndef SYNTHESIS
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff <= 6'd48 || step_ff == flfr_pkg::IDLE_STEP) else $error("bad step");
   a_store_kick: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && res_ff.store_address) |-> res_ff.watchdog_kick) else $error("store w/o kick");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !out_ready) |=> valid_ff && $stable(res_ff)) else $error("result lost");
`endif

endmodule

### tb/fire_loop_frame_responder_core_test.sv
// ----------------------------------------------------------------------------
// fire_loop_frame_responder_core_test
// Self-checking bench for the alarm loop responder: drives edge, timeout,
// tick, key and PWM transactions, predicts each result in-bench and checks
// every rsp_ transaction in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module fire_loop_frame_responder_core_test;

   timeunit 1ns;
   timeprecision 1ps;

   // kinds the block has no use for; it must answer with the LED level only
   localparam logic [2:0] KIND_SPARE_LO = 3'd5;
   localparam logic [2:0] KIND_SPARE_HI = 3'd7;
   localparam int         CYCLE_LIMIT   = 600000;
   localparam int         ITEM_TARGET   = 1300;
   localparam int         CALM_AFTER    = 1150;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [6:0]  csr_wdata;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // kind[2:0], line_high[3], interval[11:4], key_pressed[12]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // reply_pulse[0], led_on[1], store_address[2],
                             // new_address[9:3], watchdog_kick[10]

   fire_loop_frame_responder_core u_top (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // 12 ns clock
   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Responder model state (mirrors the block after every accepted event)
   // ---------------------------------------------------------------------
   logic [5:0] frame_pos;       // 63 = idle, 0..48 in a frame
   logic [2:0] cmd_sr;
   logic [6:0] addr_sr;
   logic [2:0] seq_state;       // progress through the 7F-55-25-65-3C/3B sequence
   logic [7:0] reply_sr;
   logic       reply_par;
   logic [3:0] irq_slots_left;
   logic       alarm_on;
   logic       alarm_req;
   logic       led_cmd;
   logic       led_ph;
   logic       led_lvl;
   logic       flash_ok;
   logic [6:0] my_addr;

   flfr_pkg::result_type pending_results[$];
   int         errors = 0;
   int         sent_items = 0;
   bit         calm = 0;        // no idling on either side
   int         cycles = 0;

   task automatic model_reset();
      frame_pos = flfr_pkg::IDLE_STEP;
      cmd_sr = '0; addr_sr = '0; seq_state = '0; reply_sr = '0; reply_par = 0;
      irq_slots_left = '0; alarm_on = 0; alarm_req = 0;
      led_cmd = 0; led_ph = 0; led_lvl = 0; flash_ok = 1; my_addr = '0;
   endtask

   function automatic bit is_selected();
      return addr_sr == my_addr && my_addr != 0;
   endfunction

   function automatic logic [7:0] status_word();
      return alarm_on ? 8'd64 : 8'd16;
   endfunction

   task automatic shift_reply(input logic [7:0] mask, input bit count_par,
                              inout logic pulse);
      if ((reply_sr & mask) != 0) begin
         if (count_par) reply_par ^= 1'b1;
         pulse = 1'b1;
      end
      reply_sr = reply_sr << 1;
   endtask

   // reply behavior on a falling loop edge inside a bit slot
   task automatic reply_slot(output logic pulse);
      logic [5:0] s;
      s = frame_pos;
      pulse = 1'b0;
      if (s == 6'd11) begin
         reply_par = 0;
         if (irq_slots_left > 0) begin
            pulse = 1'b1;
            if (is_selected()) reply_sr = status_word();
         end else begin
            reply_sr = status_word();
         end
         return;
      end
      if (is_selected()) begin
         if (s < 19) begin
            shift_reply(8'd64, 1'b1, pulse);
            if (s == 18) reply_sr = alarm_on ? 8'd5 : 8'd2;
         end else if (s < 22) begin
            shift_reply(8'd4, 1'b1, pulse);
            if (s == 21) reply_sr = flfr_pkg::DEV_TYPE;
         end else if (s < 25) begin
            shift_reply(8'd4, 1'b1, pulse);
            if (s == 24) reply_sr = {1'b0, my_addr};
         end else if (s < 32) begin
            shift_reply(8'd64, 1'b1, pulse);
         end else if (s == 32) begin
            reply_par ^= 1'b1;
            pulse = 1'b1;
         end else if (s == 41) begin
            if (reply_par) pulse = 1'b1;
         end
      end
      if (irq_slots_left > 0) begin
         if (s == 41) reply_sr = {1'b0, my_addr};
         if (s > 41 && s < 49) begin
            shift_reply(8'd64, 1'b0, pulse);
            if (s == 48) irq_slots_left = irq_slots_left - 1'b1;
         end
      end
   endtask

   // command/address header complete: sequences, LED command and alarm arming
   task automatic header_complete(inout logic store, inout logic [6:0] naddr);
      if (addr_sr == flfr_pkg::SEQ_ADDR0) begin
         seq_state = 3'd1;
         frame_pos = '0;
      end else begin
         case (seq_state)
            3'd1: seq_state = (addr_sr == flfr_pkg::SEQ_ADDR1) ? 3'd2 : 3'd0;
            3'd2: seq_state = (addr_sr == flfr_pkg::SEQ_ADDR2) ? 3'd3 : 3'd0;
            3'd3: seq_state = (addr_sr == flfr_pkg::SEQ_ADDR3) ? 3'd4 : 3'd0;
            3'd4: begin
               if (addr_sr == flfr_pkg::SEQ_WRITE) seq_state = 3'd5;
               else if (addr_sr == flfr_pkg::SEQ_READ) seq_state = 3'd6;
               else seq_state = 3'd0;
            end
            3'd5: begin
               if (addr_sr != 0 && addr_sr != 7'd127 && addr_sr != my_addr) begin
                  store = 1'b1;
                  naddr = addr_sr;
                  my_addr = addr_sr;
               end
               seq_state = 3'd0;
               frame_pos = '0;
            end
            default: ;
         endcase
      end
      if (frame_pos == 0) return;
      if (seq_state == 3'd6) begin
         if (my_addr != 0) begin
            addr_sr = my_addr;
            if (flash_ok) begin
               led_lvl = 1; flash_ok = 0;
            end
         end else begin
            frame_pos = '0;
         end
         seq_state = 3'd0;
         return;
      end
      if (alarm_req) begin
         alarm_req = 0;
         if (alarm_on) irq_slots_left = 4'd8;
      end
      if (is_selected()) begin
         if (cmd_sr[2]) begin
            if (!led_cmd) begin
               led_cmd = 1; led_lvl = 1; led_ph = 1;
            end
         end else if (led_cmd) begin
            led_cmd = 0; led_lvl = 0; led_ph = 0;
         end else if (flash_ok) begin
            led_lvl = 1; flash_ok = 0;
         end
      end else if (irq_slots_left == 0) begin
         frame_pos = '0;
      end
   endtask

   task automatic predict_response(input flfr_pkg::item_type it,
                                   output flfr_pkg::result_type r);
      logic       bitval;
      r = '0;
      case (it.kind)
         flfr_pkg::KIND_EDGE: begin
            if (frame_pos == flfr_pkg::IDLE_STEP) begin
               if (!it.line_high) begin
                  frame_pos = '0;
                  if (!led_cmd) led_lvl = 0;
               end
            end else if (it.line_high) begin
               if (it.interval > flfr_pkg::START_MIN) begin
                  if (it.interval < flfr_pkg::RESTART_MIN) begin
                     addr_sr = '0; cmd_sr = '0; frame_pos = 6'd1;
                     if (!led_cmd) led_lvl = 0;
                  end else begin
                     frame_pos = '0;
                  end
               end else if (frame_pos > 10) begin
                  reply_slot(r.reply_pulse);
               end
            end else if (frame_pos > 0) begin
               if (it.interval > flfr_pkg::GAP_MAX) begin
                  frame_pos = '0;
               end else if (frame_pos < 11) begin
                  bitval = it.interval >= flfr_pkg::ONE_MIN;
                  if (frame_pos < 4) cmd_sr = {cmd_sr[1:0], bitval};
                  else addr_sr = {addr_sr[5:0], bitval};
                  frame_pos = frame_pos + 1'b1;
                  if (frame_pos == 11) begin
                     r.watchdog_kick = 1'b1;
                     header_complete(r.store_address, r.new_address);
                  end
               end else begin
                  frame_pos = (frame_pos < 48) ? frame_pos + 1'b1 : 6'd0;
               end
            end
         end
         flfr_pkg::KIND_TIMEOUT: begin
            frame_pos = flfr_pkg::IDLE_STEP;
            addr_sr = '0; cmd_sr = '0;
            if (!led_cmd) led_lvl = 0;
         end
         flfr_pkg::KIND_HALFSEC: flash_ok = 1;
         flfr_pkg::KIND_KEY: begin
            if (it.key_pressed) begin
               if (!alarm_on && !led_cmd && irq_slots_left == 0) alarm_req = 1;
               alarm_on = 1;
            end else begin
               alarm_on = 0;
            end
         end
         flfr_pkg::KIND_PWM: begin
            if (led_cmd) begin
               led_ph ^= 1'b1;
               led_lvl = led_ph;
            end
         end
         default: ;
      endcase
      r.led_on = led_lvl;
   endtask

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // one req_ transaction; inputs move at the falling edge, handshake is
   // sampled at the rising edge, prediction happens on acceptance
   task automatic send_event(input logic [2:0] kind, input logic high,
                             input logic [7:0] ival, input logic key);
      flfr_pkg::item_type   it;
      flfr_pkg::result_type r;
      if (sent_items >= CALM_AFTER) calm = 1;
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      it.kind = kind; it.line_high = high; it.interval = ival; it.key_pressed = key;
      req_tdata  = {3'b000, key, ival, high, kind};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_response(it, r);
      pending_results.push_back(r);
      sent_items++;
      @(negedge clock);
   endtask

   function automatic logic [7:0] short_width();
      return 8'($urandom_range(0, 35));
   endfunction

   // write the boot address once every result is back and the engine is quiet
   task automatic load_boot_address(input logic [6:0] value);
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      @(negedge clock);
      csr_wdata = value;
      csr_we    = 1'b1;
      @(negedge clock);
      csr_we    = 1'b0;
      my_addr   = value;
   endtask

   // one well-formed frame: wake when idle, start, 10 header bits, then reply slots
   task automatic send_frame(input logic [2:0] cmd, input logic [6:0] addr,
                             input int slots);
      logic [9:0] hdr;
      hdr = {cmd, addr};
      if (frame_pos == flfr_pkg::IDLE_STEP)
         send_event(flfr_pkg::KIND_EDGE, 1'b0, 8'($urandom), 1'b0);
      send_event(flfr_pkg::KIND_EDGE, 1'b1, 8'($urandom_range(36, 144)), 1'b0);
      for (int i = 9; i >= 0; i--) begin
         send_event(flfr_pkg::KIND_EDGE, 1'b1, short_width(), 1'b0);
         send_event(flfr_pkg::KIND_EDGE, 1'b0,
                    hdr[i] ? 8'($urandom_range(17, 80)) : 8'($urandom_range(0, 16)),
                    1'b0);
      end
      for (int k = 0; k < slots && frame_pos != 0 && frame_pos != flfr_pkg::IDLE_STEP;
           k++) begin
         send_event(flfr_pkg::KIND_EDGE, 1'b1, short_width(), 1'b0);
         if ($urandom_range(0, 30) == 0)
            send_event(flfr_pkg::KIND_KEY, 1'b0, 8'($urandom), 1'($urandom));
         send_event(flfr_pkg::KIND_EDGE, 1'b0, 8'($urandom_range(0, 80)), 1'b0);
      end
   endtask

   task automatic send_sequence(input bit do_write, input logic [6:0] target);
      send_frame(3'($urandom), flfr_pkg::SEQ_ADDR0, 2);
      send_frame(3'($urandom), flfr_pkg::SEQ_ADDR1, 2);
      send_frame(3'($urandom), flfr_pkg::SEQ_ADDR2, 2);
      send_frame(3'($urandom), flfr_pkg::SEQ_ADDR3, 2);
      send_frame(3'($urandom), do_write ? flfr_pkg::SEQ_WRITE : flfr_pkg::SEQ_READ, 38);
      if (do_write) send_frame(3'($urandom), target, 38);
   endtask

   task automatic send_noise();
      logic [2:0] k;
      k = $urandom_range(0, 9) == 0 ? 3'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI))
                                    : 3'($urandom_range(flfr_pkg::KIND_EDGE,
                                                        flfr_pkg::KIND_PWM));
      send_event(k, 1'($urandom), 8'($urandom), 1'($urandom));
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_basic_events();
      send_event(flfr_pkg::KIND_EDGE, 1'b1, 8'd255, 1'b1);     // falling edge while idle
      send_event(flfr_pkg::KIND_PWM, 1'b0, 8'd0, 1'b0);        // PWM with no LED command
      send_event(flfr_pkg::KIND_TIMEOUT, 1'b0, 8'd0, 1'b0);    // timeout with no frame
      for (int k = KIND_SPARE_LO; k <= KIND_SPARE_HI; k++)
         send_event(k[2:0], 1'b1, 8'hff, 1'b1);
      send_event(flfr_pkg::KIND_HALFSEC, 1'b1, 8'h00, 1'b1);
      send_event(flfr_pkg::KIND_KEY, 1'b0, 8'h00, 1'b1);
      send_event(flfr_pkg::KIND_KEY, 1'b1, 8'hff, 1'b0);
      send_event(flfr_pkg::KIND_EDGE, 1'b0, 8'd0, 1'b0);       // wake
      send_event(flfr_pkg::KIND_EDGE, 1'b1, 8'd255, 1'b0);     // restart width
      send_event(flfr_pkg::KIND_EDGE, 1'b1, 8'd144, 1'b0);     // start
      send_event(flfr_pkg::KIND_EDGE, 1'b0, 8'd0, 1'b0);       // zero bit, narrowest
      send_event(flfr_pkg::KIND_EDGE, 1'b0, 8'd80, 1'b0);      // one bit, widest
      send_event(flfr_pkg::KIND_EDGE, 1'b0, 8'd81, 1'b0);      // gap too long
      send_event(flfr_pkg::KIND_EDGE, 1'b1, 8'd36, 1'b0);
      send_event(flfr_pkg::KIND_EDGE, 1'b0, 8'd17, 1'b0);
      send_event(flfr_pkg::KIND_TIMEOUT, 1'b1, 8'd255, 1'b1);
   endtask

   // addressed frames with status replies, LED command, flash and PWM
   task automatic test_addressed_frames(input int count);
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0)
            send_event(flfr_pkg::KIND_KEY, 1'b0, 8'($urandom), 1'($urandom));
         send_frame(3'($urandom), $urandom_range(0, 2) != 0 ? my_addr : 7'($urandom),
                    $urandom_range(0, 3) == 0 ? $urandom_range(1, 37) : 38);
         repeat ($urandom_range(0, 3))
            send_event(flfr_pkg::KIND_PWM, 1'b0, 8'($urandom), 1'($urandom));
         if ($urandom_range(0, 2) == 0)
            send_event(flfr_pkg::KIND_HALFSEC, 1'b0, 8'($urandom), 1'b0);
      end
   endtask

   // alarm key raised so the interrupt slots carry the device address
   task automatic test_alarm_slots(input int count);
      for (int n = 0; n < count; n++) begin
         send_event(flfr_pkg::KIND_KEY, 1'b0, 8'($urandom), 1'b0);
         send_event(flfr_pkg::KIND_KEY, 1'b0, 8'($urandom), 1'b1);
         send_frame(3'($urandom), 7'($urandom), 38);
         send_frame(3'($urandom), my_addr, 38);
      end
   endtask

   task automatic test_address_sequences(input int count);
      logic [6:0] target;
      for (int n = 0; n < count; n++) begin
         target = $urandom_range(0, 3) == 0 ? my_addr : 7'($urandom);
         send_sequence($urandom_range(0, 2) != 0, target);
         if ($urandom_range(0, 3) == 0)
            send_sequence(1'b1, flfr_pkg::SEQ_ADDR1);    // full write sequence with 55 as the target address
      end
   endtask

   task automatic test_random_mix();
      while (sent_items < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0, 1, 2: test_addressed_frames(1);
            3:       test_alarm_slots(1);
            4:       test_address_sequences(1);
            5:       send_frame(3'($urandom), 7'($urandom), $urandom_range(0, 38));
            default: repeat ($urandom_range(1, 8)) send_noise();
         endcase
      end
   endtask

   // ---------------------------------------------------------------------
   // Result checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      flfr_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result transaction, data %h", rsp_tdata);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[0] !== want.reply_pulse) begin
               $error("reply_pulse: expected %0d actual %0d", want.reply_pulse, rsp_tdata[0]);
               errors++;
            end
            if (rsp_tdata[1] !== want.led_on) begin
               $error("led_on: expected %0d actual %0d", want.led_on, rsp_tdata[1]);
               errors++;
            end
            if (rsp_tdata[2] !== want.store_address) begin
               $error("store_address: expected %0d actual %0d",
                      want.store_address, rsp_tdata[2]);
               errors++;
            end
            if (rsp_tdata[9:3] !== want.new_address) begin
               $error("new_address: expected %0d actual %0d",
                      want.new_address, rsp_tdata[9:3]);
               errors++;
            end
            if (rsp_tdata[10] !== want.watchdog_kick) begin
               $error("watchdog_kick: expected %0d actual %0d",
                      want.watchdog_kick, rsp_tdata[10]);
               errors++;
            end
         end
      end
   end

   // result-side back-pressure in bursts
   initial begin
      rsp_tready = 1'b1;
      forever begin
         @(negedge clock);
         if (!calm && !reset && $urandom_range(0, 6) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
            rsp_tready = 1'b1;
         end
      end
   end

   // watchdog on the whole run
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      reset      = 1'b1;
      csr_we     = 1'b0;
      csr_wdata  = '0;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      model_reset();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_events();                 // boot address 0: unassigned device
      test_address_sequences(1);
      load_boot_address(7'd127);           // top of the range
      test_addressed_frames(1);
      test_address_sequences(1);
      load_boot_address(7'd1);
      test_addressed_frames(1);
      test_alarm_slots(1);
      load_boot_address(7'($urandom_range(2, 126)));
      test_address_sequences(1);
      load_boot_address(7'd0);
      test_alarm_slots(1);
      load_boot_address(7'($urandom_range(1, 126)));
      test_random_mix();

      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

### files.f
sv/flfr_pkg.sv
sv/flfr_queue.sv
sv/flfr_engine.sv
sv/fire_loop_frame_responder_core.sv
tb/fire_loop_frame_responder_core_test.sv
